>>> hw/rtl/urxf_pkg.sv
// Package for the 8N1 UART transceiver with receive FIFO.
// Holds FIFO sizing, reset constants and the types shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package urxf_pkg;

    // Receive FIFO sizing; the ring keeps one entry free to tell full from empty.
    localparam int FIFO_DEPTH = 256;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = (FIFO_AW > 8) ? FIFO_AW : 8;

    localparam logic [15:0] BIT_PERIOD_RESET = 16'd625;

    // Frame layout: start bit, eight data bits, stop bit.
    localparam logic [3:0] TX_IDX_IDLE  = 4'd0;
    localparam logic [3:0] TX_IDX_DATA0 = 4'd2;
    localparam logic [3:0] TX_IDX_DATA7 = 4'd9;
    localparam logic [3:0] TX_IDX_STOP  = 4'd10;
    localparam logic [3:0] RX_BITS      = 4'd8;

    // Receiver phase, one-hot.
    typedef enum logic [2:0] {
        RX_IDLE  = 3'b001,
        RX_START = 3'b010,
        RX_DATA  = 3'b100
    } rx_phase_t;

    // Completed receive byte, offered to the FIFO.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rx_push_t;

    // Transmitter line state after the current item.
    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

endpackage

>>> hw/rtl/urxf_if.sv
// Channel interfaces for the UART transceiver: input items, result items
// and the bit period write channel. No dependencies.
`timescale 1ns / 1ps

// One input item per clock tick of the serial side.
interface urxf_in_if;
    logic       valid;
    logic       ready;
    logic       rx_line;
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       pop_req;

    modport source (output valid, output rx_line, output tx_start, output tx_byte,
                    output pop_req, input ready);
    modport sink   (input valid, input rx_line, input tx_start, input tx_byte,
                    input pop_req, output ready);
endinterface

// One result item per input item.
interface urxf_out_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       tx_busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] fifo_count;

    modport source (output valid, output tx_line, output tx_busy, output rx_byte,
                    output rx_valid, output fifo_count, input ready);
    modport sink   (input valid, input tx_line, input tx_busy, input rx_byte,
                    input rx_valid, input fifo_count, output ready);
endinterface

// Bit period write channel.
interface urxf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/uart_8n1_transceiver_rx_fifo_core.sv
// Top level of the 8N1 UART transceiver with receive FIFO.
// Depends on urxf_pkg, urxf_if, urxf_rx and urxf_tx.
//
//  Channel     Dir   Payload                                         Accepted when
//  item_in     in    rx_line, tx_start, tx_byte, pop_req             valid && ready
//  result_out  out   tx_line, tx_busy, rx_byte, rx_valid, fifo_count valid && ready
//  cfg         in    data = bit_period (16 bits)                     valid && ready
//
// One item per cycle while result_out is not stalled; each item is one tick of
// the serial clock domain. An item is held in the input register and its result
// is then registered in the output register. A stalled result_out holds the
// item in the input register; a new item is still taken as long as the output
// register can be refilled in that cycle. The FIFO head is read ahead from the
// byte memory into a register at rd_ptr_next, with a bypass for a byte written
// at the head address. Reset gives bit_period 625.
`timescale 1ns / 1ps

module uart_8n1_transceiver_rx_fifo_core (
    input  logic clk,
    input  logic rst_n,
    urxf_in_if.sink    item_in,
    urxf_out_if.source result_out,
    urxf_cfg_if.sink   cfg
);
    import urxf_pkg::*;

    logic [15:0]        bit_period_reg;

    // Input register.
    logic               in_valid_reg;
    logic               rx_line_reg;
    logic               tx_start_reg;
    logic [7:0]         tx_byte_reg;
    logic               pop_req_reg;

    // Output register.
    logic               out_valid_reg;
    logic               tx_line_reg;
    logic               tx_busy_reg;
    logic [7:0]         rx_byte_reg;
    logic               rx_valid_reg;
    logic [7:0]         fifo_count_reg;

    // FIFO.
    logic [7:0]         store_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [7:0]         head_mem_reg;
    logic               head_byp_reg;
    logic [7:0]         head_byp_data_reg;
    logic [7:0]         head_data;
    logic               do_pop;
    logic               do_push;
    logic [FIFO_AW-1:0] wr_inc;
    logic [FIFO_AW-1:0] rd_inc;
    logic [CNT_W-1:0]   count_w;
    logic [7:0]         count_sat;

    logic               step;
    rx_push_t           push;
    tx_status_t         tx_status;

    // Handshakes.
    assign step           = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready  = !in_valid_reg || step;
    assign cfg.ready      = 1'b1;
    assign result_out.valid      = out_valid_reg;
    assign result_out.tx_line    = tx_line_reg;
    assign result_out.tx_busy    = tx_busy_reg;
    assign result_out.rx_byte    = rx_byte_reg;
    assign result_out.rx_valid   = rx_valid_reg;
    assign result_out.fifo_count = fifo_count_reg;

    // Bit period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            bit_period_reg <= cfg.data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            rx_line_reg  <= item_in.rx_line;
            tx_start_reg <= item_in.tx_start;
            tx_byte_reg  <= item_in.tx_byte;
            pop_req_reg  <= item_in.pop_req;
        end
    end

    urxf_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_line    (rx_line_reg),
        .bit_period (bit_period_reg),
        .push       (push)
    );

    urxf_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .tx_start   (tx_start_reg),
        .tx_byte    (tx_byte_reg),
        .bit_period (bit_period_reg),
        .status     (tx_status)
    );

    // Ring pointers; the pop is taken before the push so it frees space.
    assign wr_inc  = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + FIFO_AW'(1);
    assign rd_inc  = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + FIFO_AW'(1);
    assign do_pop  = step && pop_req_reg && (rd_ptr_reg != wr_ptr_reg);
    assign rd_ptr_next = do_pop ? rd_inc : rd_ptr_reg;
    assign do_push = push.valid && (wr_inc != rd_ptr_next);
    assign wr_ptr_next = do_push ? wr_inc : wr_ptr_reg;

    // Fill level after this item, saturated to the 8-bit field.
    always_comb
    begin
        if (wr_ptr_next >= rd_ptr_next)
        begin
            count_w = CNT_W'(wr_ptr_next - rd_ptr_next);
        end
        else
        begin
            count_w = CNT_W'(CNT_W'(wr_ptr_next) + CNT_W'(FIFO_DEPTH) - CNT_W'(rd_ptr_next));
        end
        count_sat = (count_w > CNT_W'(255)) ? 8'hFF : count_w[7:0];
    end

    assign head_data = head_byp_reg ? head_byp_data_reg : head_mem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Byte store: one write port, head registered from rd_ptr_next.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[wr_ptr_reg] <= push.data;
        end
        head_mem_reg <= store_mem[rd_ptr_next];
    end

    // Bypass for a byte that lands on the head address in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_byp_reg <= 1'b0;
        end
        else
        begin
            head_byp_reg <= do_push && (wr_ptr_reg == rd_ptr_next);
        end
    end

    always_ff @(posedge clk)
    begin
        head_byp_data_reg <= push.data;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_out.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tx_line_reg    <= tx_status.line;
            tx_busy_reg    <= tx_status.busy;
            rx_byte_reg    <= do_pop ? head_data : 8'd0;
            rx_valid_reg   <= do_pop;
            fifo_count_reg <= count_sat;
        end
    end

endmodule

>>> hw/rtl/urxf_rx.sv
// UART 8N1 receiver: start edge detect, mid-bit start check, data sampling.
// Depends on urxf_pkg.
`timescale 1ns / 1ps

module urxf_rx (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               rx_line,
    input  logic [15:0]        bit_period,
    output urxf_pkg::rx_push_t push
);
    import urxf_pkg::*;

    rx_phase_t   phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  shift_reg, shift_next;
    logic        prev_reg;
    logic [7:0]  shift_or;

    assign shift_or = shift_reg | (8'(rx_line) << idx_reg[2:0]);

    // Next state for one tick of the serial line.
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        push.valid = 1'b0;
        push.data  = shift_or;
        case (phase_reg)
            RX_IDLE:
            begin
                if (prev_reg && !rx_line)
                begin
                    phase_next = RX_START;
                    timer_next = bit_period >> 1;
                end
            end
            RX_START:
            begin
                if (timer_reg > 16'd1)
                begin
                    timer_next = timer_reg - 16'd1;
                end
                else if (rx_line)
                begin
                    phase_next = RX_IDLE;
                end
                else
                begin
                    phase_next = RX_DATA;
                    idx_next   = 4'd0;
                    shift_next = 8'd0;
                    timer_next = bit_period;
                end
            end
            RX_DATA:
            begin
                if (timer_reg > 16'd1)
                begin
                    timer_next = timer_reg - 16'd1;
                end
                else
                begin
                    shift_next = shift_or;
                    idx_next   = idx_reg + 4'd1;
                    timer_next = bit_period;
                    if (idx_next >= RX_BITS)
                    begin
                        push.valid = 1'b1;
                        phase_next = RX_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = RX_IDLE;
            end
        endcase
        push.valid = push.valid & step;
    end

    // State advances only on processed items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RX_IDLE;
            timer_reg <= 16'd0;
            idx_reg   <= 4'd0;
            shift_reg <= 8'd0;
            prev_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            prev_reg  <= rx_line;
        end
    end

endmodule

>>> hw/rtl/urxf_tx.sv
// UART 8N1 transmitter: start bit, eight data bits LSB first, stop bit.
// Depends on urxf_pkg.
`timescale 1ns / 1ps

module urxf_tx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 tx_start,
    input  logic [7:0]           tx_byte,
    input  logic [15:0]          bit_period,
    output urxf_pkg::tx_status_t status
);
    import urxf_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  shift_reg, shift_next;
    logic        level_reg, level_next;
    logic [3:0]  idx_inc;
    logic [3:0]  bit_sel;

    assign idx_inc = idx_reg + 4'd1;
    assign bit_sel = idx_inc - TX_IDX_DATA0;

    // Next state for one tick.
    always_comb
    begin
        idx_next   = idx_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        level_next = level_reg;
        if (idx_reg == TX_IDX_IDLE)
        begin
            if (tx_start)
            begin
                shift_next = tx_byte;
                idx_next   = 4'd1;
                level_next = 1'b0;
                timer_next = bit_period;
            end
        end
        else if (timer_reg > 16'd1)
        begin
            timer_next = timer_reg - 16'd1;
        end
        else
        begin
            idx_next   = idx_inc;
            timer_next = bit_period;
            if (idx_inc >= TX_IDX_DATA0 && idx_inc <= TX_IDX_DATA7)
            begin
                level_next = shift_reg[bit_sel[2:0]];
            end
            else if (idx_inc == TX_IDX_STOP)
            begin
                level_next = 1'b1;
            end
            else
            begin
                idx_next   = TX_IDX_IDLE;
                level_next = 1'b1;
                timer_next = 16'd0;
            end
        end
    end

    // Line state as it stands after this item.
    assign status.line = level_next;
    assign status.busy = (idx_next != TX_IDX_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= TX_IDX_IDLE;
            timer_reg <= 16'd0;
            shift_reg <= 8'd0;
            level_reg <= 1'b1;
        end
        else if (step)
        begin
            idx_reg   <= idx_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            level_reg <= level_next;
        end
    end

endmodule

>>> verif/urxf_checker.sv
// Self-checking monitor for the 8N1 UART transceiver with receive FIFO.
// Watches the item, result and bit period channels and predicts every result.
// Depends on urxf_pkg and urxf_if.
`timescale 1ns / 1ps

module urxf_checker (
    input  logic clk,
    input  logic rst_n,
    urxf_in_if   item_in,
    urxf_out_if  result_out,
    urxf_cfg_if  cfg,
    output int   errors,
    output int   pending
);

    import urxf_pkg::*;

    // Frame position of the start bit; the package names the others.
    localparam logic [3:0] TX_IDX_START = 4'd1;
    localparam int         MAX_REPORTS  = 40;

    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] fifo_count;
    } uart_tick_out_t;

    uart_tick_out_t predicted_outputs[$];

    // Predicted UART state.
    logic [7:0]  rx_mem [FIFO_DEPTH];
    int          wr_ptr;
    int          rd_ptr;
    rx_phase_t   rx_ph;
    logic [15:0] rx_tmr;
    logic [3:0]  rx_bits;
    logic [7:0]  rx_sh;
    logic        line_prev;
    logic [15:0] tx_tmr;
    logic [3:0]  tx_idx;
    logic [7:0]  tx_sh;
    logic        tx_lvl;
    logic [15:0] bit_period;
    int          result_index;

    initial
    begin
        errors = 0;
        result_index = 0;
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_REPORTS)
            $display("[%0t] result %0d: %s", $realtime, result_index, msg);
        errors++;
    endtask

    task automatic clear_uart_state();
        for (int i = 0; i < FIFO_DEPTH; i++)
            rx_mem[i] = 8'h00;
        wr_ptr     = 0;
        rd_ptr     = 0;
        rx_ph      = RX_IDLE;
        rx_tmr     = '0;
        rx_bits    = '0;
        rx_sh      = '0;
        line_prev  = 1'b1;
        tx_tmr     = '0;
        tx_idx     = TX_IDX_IDLE;
        tx_sh      = '0;
        tx_lvl     = 1'b1;
        bit_period = BIT_PERIOD_RESET;
    endtask

    // One serial clock tick: pop first, then receiver, then transmitter.
    task automatic advance_uart_tick(input logic line, input logic start,
                                     input logic [7:0] tx_data, input logic pop,
                                     output uart_tick_out_t res);
        int nxt;
        int cnt;
        res = '0;

        if (pop && rd_ptr != wr_ptr)
        begin
            res.rx_byte  = rx_mem[rd_ptr];
            res.rx_valid = 1'b1;
            rd_ptr       = (rd_ptr + 1) % FIFO_DEPTH;
        end

        // Receiver: edge detect, start bit check at half a bit, then data bits.
        if (rx_ph == RX_IDLE)
        begin
            if (line_prev && !line)
            begin
                rx_ph  = RX_START;
                rx_tmr = bit_period >> 1;
            end
        end
        else if (rx_tmr > 16'd1)
        begin
            rx_tmr = rx_tmr - 16'd1;
        end
        else if (rx_ph == RX_START)
        begin
            if (line)
            begin
                rx_ph = RX_IDLE;
            end
            else
            begin
                rx_ph   = RX_DATA;
                rx_bits = '0;
                rx_sh   = '0;
                rx_tmr  = bit_period;
            end
        end
        else
        begin
            rx_sh   = rx_sh | (8'(line) << rx_bits[2:0]);
            rx_bits = rx_bits + 4'd1;
            rx_tmr  = bit_period;
            if (rx_bits >= RX_BITS)
            begin
                // A full ring drops the new byte.
                nxt = (wr_ptr + 1) % FIFO_DEPTH;
                if (nxt != rd_ptr)
                begin
                    rx_mem[wr_ptr] = rx_sh;
                    wr_ptr         = nxt;
                end
                rx_ph = RX_IDLE;
            end
        end
        line_prev = line;

        // Transmitter: busy is judged from the index at the end of the tick.
        if (tx_idx == TX_IDX_IDLE)
        begin
            if (start)
            begin
                tx_sh  = tx_data;
                tx_idx = TX_IDX_START;
                tx_lvl = 1'b0;
                tx_tmr = bit_period;
            end
        end
        else if (tx_tmr > 16'd1)
        begin
            tx_tmr = tx_tmr - 16'd1;
        end
        else
        begin
            tx_idx = tx_idx + 4'd1;
            tx_tmr = bit_period;
            if (tx_idx >= TX_IDX_DATA0 && tx_idx <= TX_IDX_DATA7)
            begin
                tx_lvl = tx_sh[3'(tx_idx - TX_IDX_DATA0)];
            end
            else if (tx_idx == TX_IDX_STOP)
            begin
                tx_lvl = 1'b1;
            end
            else
            begin
                tx_idx = TX_IDX_IDLE;
                tx_lvl = 1'b1;
                tx_tmr = '0;
            end
        end

        cnt = (wr_ptr + FIFO_DEPTH - rd_ptr) % FIFO_DEPTH;
        if (cnt > 255)
            cnt = 255;
        res.tx_line    = tx_lvl;
        res.tx_busy    = (tx_idx != TX_IDX_IDLE);
        res.fifo_count = 8'(cnt);
    endtask

    // Compare accepted results, then predict for accepted items.
    always @(posedge clk)
    begin
        uart_tick_out_t got_r;
        uart_tick_out_t want_r;
        if (!rst_n)
        begin
            clear_uart_state();
            predicted_outputs.delete();
            pending <= 0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                got_r.tx_line    = result_out.tx_line;
                got_r.tx_busy    = result_out.tx_busy;
                got_r.rx_byte    = result_out.rx_byte;
                got_r.rx_valid   = result_out.rx_valid;
                got_r.fifo_count = result_out.fifo_count;
                if (predicted_outputs.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item outstanding (%h)", got_r));
                end
                else
                begin
                    want_r = predicted_outputs.pop_front();
                    if (got_r.tx_line !== want_r.tx_line)
                        report_mismatch($sformatf("tx_line %0b, expected %0b",
                                                  got_r.tx_line, want_r.tx_line));
                    if (got_r.tx_busy !== want_r.tx_busy)
                        report_mismatch($sformatf("tx_busy %0b, expected %0b",
                                                  got_r.tx_busy, want_r.tx_busy));
                    if (got_r.rx_byte !== want_r.rx_byte)
                        report_mismatch($sformatf("rx_byte %h, expected %h",
                                                  got_r.rx_byte, want_r.rx_byte));
                    if (got_r.rx_valid !== want_r.rx_valid)
                        report_mismatch($sformatf("rx_valid %0b, expected %0b",
                                                  got_r.rx_valid, want_r.rx_valid));
                    if (got_r.fifo_count !== want_r.fifo_count)
                        report_mismatch($sformatf("fifo_count %0d, expected %0d",
                                                  got_r.fifo_count, want_r.fifo_count));
                end
                result_index++;
            end

            if (item_in.valid && item_in.ready)
            begin
                advance_uart_tick(item_in.rx_line, item_in.tx_start, item_in.tx_byte,
                                  item_in.pop_req, want_r);
                predicted_outputs.push_back(want_r);
            end

            if (cfg.valid && cfg.ready)
                bit_period = cfg.data;

            pending <= predicted_outputs.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Top of the UART transceiver testbench: clock, reset, serial stimulus and verdict.
// Depends on urxf_pkg, urxf_if, the core and urxf_checker.
`timescale 1ns / 1ps

module tb_top;

    import urxf_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 400;

    // Directed sequence at zero bit period, one bit per tick.
    localparam logic [23:0] DIR_LINE  = 24'hC00FF2;
    localparam logic [23:0] DIR_START = 24'h000FFF;
    localparam logic [23:0] DIR_POP   = 24'hE00800;

    logic clk = 1'b0;
    logic rst_n;

    int mismatches;
    int results_pending;

    // Traffic shape, set per phase.
    int bit_period_now;
    int send_idle_pct;
    int stall_pct;
    int pop_pct;
    int start_pct;
    int hold_req;

    int items_sent;
    int frames_sent;
    int settings_used;
    int cycles;

    urxf_in_if  item_if ();
    urxf_out_if res_if ();
    urxf_cfg_if cfg_if ();

    uart_8n1_transceiver_rx_fifo_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    urxf_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg        (cfg_if),
        .errors     (mismatches),
        .pending    (results_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: random stalls, with an occasional long hold-off.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int period_ticks();
        return (bit_period_now == 0) ? 1 : bit_period_now;
    endfunction

    // Offer one item and wait until it is taken.
    task automatic send_tick(input logic line, input logic start,
                             input logic [7:0] tx_data, input logic pop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid    <= 1'b1;
        item_if.rx_line  <= line;
        item_if.tx_start <= start;
        item_if.tx_byte  <= tx_data;
        item_if.pop_req  <= pop;
        do
            @(posedge clk);
        while (!item_if.ready);
        items_sent++;
    endtask

    // Hold the receive line for some ticks, with random transmit and pop requests.
    task automatic send_rx_level(input logic line, input int ticks);
        repeat (ticks)
            send_tick(line, $urandom_range(99) < start_pct, 8'($urandom_range(255)),
                      $urandom_range(99) < pop_pct);
    endtask

    task automatic send_frame(input logic [7:0] data);
        int p;
        p = period_ticks();
        send_rx_level(1'b0, p);
        for (int i = 0; i < 8; i++)
            send_rx_level(data[i], p);
        send_rx_level(1'b1, p);
        send_rx_level(1'b1, $urandom_range(0, p));
        frames_sent++;
    endtask

    // Mostly clean frames, some glitches, truncations, noise; all noise if p > 64.
    task automatic run_traffic(input int n_items);
        int target;
        int pick;
        int p;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            p = period_ticks();
            if (p > 64 || pick < 10)
            begin
                repeat ($urandom_range(1, 8))
                    send_rx_level(1'($urandom_range(1)), 1);
            end
            else if (pick < 22)
            begin
                send_rx_level(1'b0, $urandom_range(1, p));
                repeat ($urandom_range(0, 8))
                    send_rx_level(1'($urandom_range(1)), p);
                send_rx_level(1'b1, p);
            end
            else
            begin
                send_frame(8'($urandom_range(255)));
            end
        end
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bit_period(input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        bit_period_now = value;
        settings_used++;
    endtask

    task automatic start_phase(input int period, input int idle_p, input int stall_p,
                               input int pop_p, input int start_p);
        wait_drain();
        write_bit_period(16'(period));
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        pop_pct       = pop_p;
        start_pct     = start_p;
    endtask

    // Main stimulus.
    initial
    begin
        rst_n            = 1'b0;
        item_if.valid    = 1'b0;
        item_if.rx_line  = 1'b1;
        item_if.tx_start = 1'b0;
        item_if.tx_byte  = 8'h00;
        item_if.pop_req  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = 16'h0000;
        send_idle_pct    = 0;
        stall_pct        = 0;
        pop_pct          = 0;
        start_pct        = 0;
        hold_req         = 0;
        items_sent       = 0;
        frames_sent      = 0;
        settings_used    = 1;
        bit_period_now   = BIT_PERIOD_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset bit period: pops on an empty FIFO, byte extremes with no request.
        send_tick(1'b1, 1'b0, 8'hFF, 1'b1);
        send_tick(1'b1, 1'b0, 8'h00, 1'b1);
        send_tick(1'b1, 1'b0, 8'hFF, 1'b0);

        // Zero period acts as one tick: aborted start bit, 0xFF and 0x00 received,
        // pop and push in one tick, requests while busy and in the final tick.
        start_phase(0, 0, 0, 0, 0);
        for (int t = 0; t < 24; t++)
            send_tick(DIR_LINE[t], DIR_START[t], (t == 0) ? 8'hFF : 8'h00, DIR_POP[t]);

        // Random phases over several bit periods and handshake shapes.
        start_phase(1, 0, 0, 20, 30);
        run_traffic(80);
        hold_req <= hold_req + 1;
        run_traffic(80);

        start_phase(2, 74, 0, 20, 30);
        run_traffic(150);

        start_phase(3, 0, 74, 20, 30);
        run_traffic(80);
        wait_drain();
        run_traffic(80);

        start_phase(5, 22, 22, 20, 30);
        run_traffic(150);

        // Build a backlog of received bytes, trickle pops against pushes, then drain.
        // At one tick per bit the start check lands on data bit 0, so keep it low.
        start_phase(0, 0, 0, 0, 30);
        repeat (22)
            send_frame(8'($urandom_range(255)) & 8'hFE);
        pop_pct = 8;
        repeat (5)
            send_frame(8'($urandom_range(255)) & 8'hFE);
        pop_pct = 75;
        send_rx_level(1'b1, 50);

        start_phase(7, 22, 22, 25, 30);
        run_traffic(200);

        start_phase(12, 74, 74, 25, 30);
        run_traffic(150);

        // Largest period last: frames never finish here.
        start_phase(16'hFFFF, 0, 22, 30, 30);
        run_traffic(60);

        wait_drain();
        repeat (8) @(posedge clk);

        $display("Run covered %0d items, %0d receive frames, %0d bit period settings",
                 items_sent, frames_sent, settings_used);
        $display("including a receive backlog, aborted start bits and busy transmit requests.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
